// File: design/ilgu_pkg.sv
package ilgu_pkg;

  localparam int DIM = 64;
  localparam int NUM_SAMPLES = 1024;
  localparam int DIM_W = $clog2(DIM);
  localparam int SMP_W = $clog2(NUM_SAMPLES);
  localparam int TAB_W = SMP_W + DIM_W;
  localparam int CNT_W = DIM_W + 1;
  localparam logic signed [31:0] Q_ONE = 32'sd65536;

  localparam logic [1:0] CFG_STEP = 2'd0;
  localparam logic [1:0] CFG_REG  = 2'd1;
  localparam logic [1:0] CFG_INV  = 2'd2;

  localparam logic REQ_FEATURE = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,    // clearing pass over memories after reset
    ST_IDLE,
    ST_MAC_RD,   // mean element read for one feature
    ST_MAC,      // multiply
    ST_MAC_ACC,  // accumulate
    ST_RD_WAIT,  // readout memory read
    ST_COEF,     // dot -> coefficient
    ST_UPD_RD,   // read mean, z, x of element c
    ST_UPD_G,    // products coef*x and s*m
    ST_UPD_A,    // alpha*g
    ST_UPD_D,    // delta, delta*inv
    ST_UPD_WR,   // write back
    ST_OUT       // result waiting
  } ilgu_state_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic        count_error;
    logic        saturated;
  } ilgu_result_t;

  function automatic logic signed [63:0] ilgu_clip32(input logic signed [63:0] v,
                                                     output logic flag);
    flag = 1'b0;
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic logic signed [31:0] ilgu_sigmoid(input logic signed [31:0] u);
    logic signed [32:0] a;
    logic signed [32:0] f;
    a = u[31] ? -{u[31], u} : {u[31], u};
    if (a >= 33'sd327680)      f = 33'sd65536;
    else if (a >= 33'sd155648) f = (a >>> 5) + 33'sd55296;
    else if (a >= 33'sd65536)  f = (a >>> 3) + 33'sd40960;
    else                       f = (a >>> 2) + 33'sd32768;
    if (u[31]) f = 33'sd65536 - f;
    return f[31:0];
  endfunction

endpackage

// File: design/incremental_logistic_gradient_update_unit.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | req_type, sample_index, label, feature,
//         |           |                       | last, weight_index
// out     | output    | out_valid / out_ready | kind, value, count_error, saturated
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
// A feature steps through accept, mean read, multiply and accumulate; a readout
// through accept and memory read. The last feature adds a coefficient step and a
// read-modify-write pass over all 64 elements of mean and z.
// One transaction is in flight; in_ready drops until it is done and any result is taken.
// After reset a clearing pass zeroes the mean and z stores.
module incremental_logistic_gradient_update_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_req_type,
  input  logic [9:0]          in_sample_index,
  input  logic signed [1:0]   in_label,
  input  logic signed [31:0]  in_feature,
  input  logic                in_last,
  input  logic [5:0]          in_weight_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kind,
  output logic signed [31:0]  out_value,
  output logic                out_count_error,
  output logic                out_saturated,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import ilgu_pkg::*;

  logic [31:0]  step_r, reg_r;
  logic [16:0]  inv_r;
  ilgu_result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 32'd65536;
      reg_r  <= '0;
      inv_r  <= 17'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STEP: step_r <= cfg_data;
        CFG_REG:  reg_r  <= cfg_data;
        CFG_INV:  inv_r  <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  ilgu_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_sample_index, .in_label,
    .in_feature, .in_last, .in_weight_index,
    .step_size(step_r), .regularization(reg_r), .inv_count(inv_r),
    .res, .res_valid(out_valid), .res_ready(out_ready));

  assign out_kind        = res.kind;
  assign out_value       = res.value;
  assign out_count_error = res.count_error;
  assign out_saturated   = res.saturated;
endmodule

// File: design/ilgu_ram.sv
module ilgu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: design/ilgu_ctrl.sv
module ilgu_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_req_type,
  input  logic [9:0]                in_sample_index,
  input  logic signed [1:0]         in_label,
  input  logic signed [31:0]        in_feature,
  input  logic                      in_last,
  input  logic [5:0]                in_weight_index,
  input  logic [31:0]               step_size,
  input  logic [31:0]               regularization,
  input  logic [16:0]               inv_count,
  output ilgu_pkg::ilgu_result_t    res,
  output logic                      res_valid,
  input  logic                      res_ready
);
  import ilgu_pkg::*;

  ilgu_state_t state_r, state_nxt;

  logic [DIM_W-1:0]      addr_r, addr_nxt;
  logic [SMP_W-1:0]      ik_r, ik_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TAB_W:0]        clr_r, clr_nxt;
  logic signed [63:0]    acc_r, acc_nxt;
  logic                  acc_sat_r, acc_sat_nxt;
  logic                  sat_r, sat_nxt;
  logic signed [1:0]     lab_r, lab_nxt;
  logic signed [31:0]    x_r, x_nxt;
  logic signed [63:0]    p_r, p_nxt;
  logic signed [63:0]    q_r, q_nxt;
  logic signed [31:0]    coef_r, coef_nxt;
  logic signed [31:0]    m_r, m_nxt;
  logic signed [31:0]    z_r, z_nxt;
  logic signed [31:0]    g_r, g_nxt;
  logic signed [31:0]    d_r, d_nxt;
  ilgu_result_t          res_r, res_nxt;

  // memories
  logic                  mw_we, zw_we, xw_we;
  logic [DIM_W-1:0]      m_waddr, m_raddr, x_waddr;
  logic [TAB_W-1:0]      z_waddr, z_raddr;
  logic [31:0]           m_wdata, z_wdata, x_wdata, m_rdata, z_rdata, x_rdata;

  ilgu_ram #(.WIDTH(32), .DEPTH(DIM)) u_mean (
    .clk, .we(mw_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata));
  ilgu_ram #(.WIDTH(32), .DEPTH(NUM_SAMPLES * DIM)) u_ztab (
    .clk, .we(zw_we), .waddr(z_waddr), .wdata(z_wdata), .raddr(z_raddr), .rdata(z_rdata));
  ilgu_ram #(.WIDTH(32), .DEPTH(DIM)) u_xbuf (
    .clk, .we(xw_we), .waddr(x_waddr), .wdata(x_wdata), .raddr(addr_r), .rdata(x_rdata));

  // arithmetic helpers
  logic signed [64:0] sum65;
  logic               f1, f2;
  logic signed [63:0] dot_c, g_c, d_c, z_c, m_c;
  logic signed [31:0] inv_c;
  logic signed [1:0]  y_c;

  assign in_ready  = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_OUT);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      cnt_r     <= '0;
      acc_r     <= '0;
      acc_sat_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      cnt_r     <= cnt_nxt;
      acc_r     <= acc_nxt;
      acc_sat_r <= acc_sat_nxt;
    end
    addr_r <= addr_nxt;
    ik_r   <= ik_nxt;
    sat_r  <= sat_nxt;
    lab_r  <= lab_nxt;
    x_r    <= x_nxt;
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    coef_r <= coef_nxt;
    m_r    <= m_nxt;
    z_r    <= z_nxt;
    g_r    <= g_nxt;
    d_r    <= d_nxt;
    res_r  <= res_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:   if (clr_r[TAB_W]) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_READ)   state_nxt = ST_RD_WAIT;
          else if (cnt_r < CNT_W'(DIM))  state_nxt = ST_MAC_RD;
          else if (in_last)              state_nxt = ST_OUT;
        end
      end
      ST_MAC_RD:  state_nxt = ST_MAC;
      ST_MAC:     state_nxt = ST_MAC_ACC;
      ST_MAC_ACC: begin
        // cnt_r still holds the count before this feature
        if (z_r[0]) state_nxt = (cnt_r == CNT_W'(DIM - 1)) ? ST_COEF : ST_OUT;
        else state_nxt = ST_IDLE;
      end
      ST_RD_WAIT: state_nxt = ST_OUT;
      ST_COEF:    state_nxt = ST_UPD_RD;
      ST_UPD_RD:  state_nxt = ST_UPD_G;
      ST_UPD_G:   state_nxt = ST_UPD_A;
      ST_UPD_A:   state_nxt = ST_UPD_D;
      ST_UPD_D:   state_nxt = ST_UPD_WR;
      ST_UPD_WR:  state_nxt = (addr_r == DIM_W'(DIM - 1)) ? ST_OUT : ST_UPD_RD;
      ST_OUT:     if (res_ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    clr_nxt = clr_r;  cnt_nxt = cnt_r;  acc_nxt = acc_r;  acc_sat_nxt = acc_sat_r;
    addr_nxt = addr_r; ik_nxt = ik_r; sat_nxt = sat_r; lab_nxt = lab_r;
    x_nxt = x_r; p_nxt = p_r; q_nxt = q_r; coef_nxt = coef_r;
    m_nxt = m_r; z_nxt = z_r; g_nxt = g_r; d_nxt = d_r; res_nxt = res_r;
    mw_we = 1'b0; zw_we = 1'b0; xw_we = 1'b0;
    m_waddr = addr_r; m_wdata = '0; m_raddr = addr_r;
    z_waddr = clr_r[TAB_W-1:0]; z_wdata = '0; z_raddr = {ik_r, addr_r};
    x_waddr = cnt_r[DIM_W-1:0]; x_wdata = in_feature;
    sum65 = '0;
    f1 = 1'b0; f2 = 1'b0;
    dot_c = '0; g_c = '0; d_c = '0; z_c = '0; m_c = '0; y_c = '0;
    inv_c = (inv_count > 17'd65536) ? Q_ONE : {15'd0, inv_count};
    case (state_r)
      ST_CLEAR: begin
        zw_we   = 1'b1;
        mw_we   = 1'b1;
        m_waddr = clr_r[DIM_W-1:0];
        clr_nxt = clr_r + 1'b1;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_READ) begin
            m_raddr = in_weight_index[DIM_W-1:0];
          end else if (cnt_r < CNT_W'(DIM)) begin
            xw_we    = 1'b1;
            addr_nxt = cnt_r[DIM_W-1:0];
            m_raddr  = cnt_r[DIM_W-1:0];
            x_nxt    = in_feature;
            lab_nxt  = in_label;
            ik_nxt   = in_sample_index[SMP_W-1:0];
            z_nxt    = {31'd0, in_last};
          end else begin
            cnt_nxt = CNT_W'(DIM + 1);
            if (in_last) begin
              res_nxt     = '{kind: 1'b0, value: '0, count_error: 1'b1, saturated: 1'b0};
              cnt_nxt     = '0;
              acc_nxt     = '0;
              acc_sat_nxt = 1'b0;
            end
          end
        end
      end
      ST_MAC: p_nxt = $signed(m_rdata) * x_r;
      ST_MAC_ACC: begin
        sum65 = {acc_r[63], acc_r} + {p_r[63], p_r};
        if (sum65[64] != sum65[63]) begin
          acc_nxt     = sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
          acc_sat_nxt = 1'b1;
        end else begin
          acc_nxt = sum65[63:0];
        end
        cnt_nxt = cnt_r + 1'b1;
        if (z_r[0] && cnt_r + 1'b1 != CNT_W'(DIM)) begin
          res_nxt     = '{kind: 1'b0, value: '0, count_error: 1'b1, saturated: 1'b0};
          cnt_nxt     = '0;
          acc_nxt     = '0;
          acc_sat_nxt = 1'b0;
        end
      end
      ST_RD_WAIT: res_nxt = '{kind: 1'b1, value: m_rdata, count_error: 1'b0, saturated: 1'b0};
      ST_COEF: begin
        dot_c   = ilgu_clip32(acc_r >>> 16, f1);
        sat_nxt = acc_sat_r | f1;
        y_c     = (lab_r == 2'sd1) ? 2'sd1 : (lab_r[1] ? -2'sd1 : 2'sd0);
        if (y_c == 2'sd0)      coef_nxt = '0;
        else if (y_c == 2'sd1) coef_nxt = -ilgu_sigmoid(-dot_c[31:0]);
        else                   coef_nxt = ilgu_sigmoid(dot_c[31:0]);
        // -dot of INT32_MIN wraps; sigmoid saturates there anyway
        if (y_c == 2'sd1 && dot_c[31:0] == 32'h8000_0000) coef_nxt = -Q_ONE;
        addr_nxt = '0;
      end
      ST_UPD_RD: ;
      ST_UPD_G: begin
        m_nxt = m_rdata;
        z_nxt = z_rdata;
        p_nxt = coef_r * $signed(x_rdata);
        q_nxt = $signed({1'b0, regularization}) * $signed(m_rdata);
      end
      ST_UPD_A: begin
        g_c   = (p_r >>> 16) + (q_r >>> 16);
        g_c   = ilgu_clip32(g_c, f1);
        sat_nxt = sat_r | f1;
        p_nxt = $signed({1'b0, step_size}) * $signed(g_c[31:0]);
      end
      ST_UPD_D: begin
        d_c   = 64'(m_r) - 64'(z_r) - (p_r >>> 16);
        d_c   = ilgu_clip32(d_c, f1);
        sat_nxt = sat_r | f1;
        d_nxt = d_c[31:0];
        q_nxt = $signed(d_c[31:0]) * inv_c;
      end
      ST_UPD_WR: begin
        z_c = ilgu_clip32(64'(z_r) + 64'(d_r), f1);
        m_c = ilgu_clip32(64'(m_r) + (q_r >>> 16), f2);
        sat_nxt = sat_r | f1 | f2;
        zw_we   = 1'b1;
        z_waddr = {ik_r, addr_r};
        z_wdata = z_c[31:0];
        mw_we   = 1'b1;
        m_wdata = m_c[31:0];
        addr_nxt = addr_r + 1'b1;
        if (addr_r == DIM_W'(DIM - 1)) begin
          res_nxt = '{kind: 1'b0, value: coef_r, count_error: 1'b0,
                      saturated: sat_r | f1 | f2};
          cnt_nxt     = '0;
          acc_nxt     = '0;
          acc_sat_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end
endmodule

// File: design/ilgu_checker.sv
module ilgu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [31:0] out_value,
  input logic        out_count_error,
  input logic        out_saturated
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result dropped");
  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind |-> !out_count_error && !out_saturated)
    else $error("readout flags set");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count_error |-> out_value == 32'd0 && !out_saturated)
    else $error("count error with data");
endmodule

bind incremental_logistic_gradient_update_unit ilgu_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_kind,
  .out_value, .out_count_error, .out_saturated);
